// ===== hw/rtl/amdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared widths, codes and control/status bundles of the adjacency matrix
// depth-first search unit.
// ----------------------------------------------------------------------------
package amdfs_pkg;

    // Node index, node count and visit order widths
    localparam int NODE_W    = 4;
    localparam int MAX_NODES = 16;
    localparam int CNT_W     = 5;
    localparam int ORD_W     = 5;

    // Node count after reset
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_SEARCH   = 2'd2
    } t_cmd;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_READ,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;      // take the input item this cycle
        logic stack_read;  // read the top of the stack
        logic pop;         // take the popped node, count the visit
        logic push;        // push lowest unvisited neighbor
        logic emit_resp;   // load single command result
        logic emit_step;   // load search step result
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic req_search;  // pending item is an in-range search
        logic found;       // popped node is the destination
        logic cand_any;    // an unvisited neighbor remains to push
        logic step_last;   // current search step is the final one
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

// ===== hw/rtl/adjacency_matrix_dfs_search_unit.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_search_unit
// Undirected graph in an adjacency bit matrix with depth-first search.
// ----------------------------------------------------------------------------
// Commands: clear (0) zeroes the graph, add edge (1) sets both symmetric
// bits of node_a/node_b, search (2) walks the graph depth first from node_a
// to node_b and returns one item per popped node with its 1-based visit
// order; the final item carries last=1 and found=1 if node_b was reached.
// Out-of-range nodes of add edge or search and command 3 give one item with
// status=1. One command is worked on at a time. For each popped node a
// search goes through a stack read, a pop, a neighbor check that pushes the
// unvisited neighbors through the single stack write port, and an emit.
// Output back-pressure stalls the response and emit steps. The node count
// register is written by i_cfg_we / i_cfg_data and resets to 16; values
// above 16 act as 16.
module adjacency_matrix_dfs_search_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [amdfs_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [amdfs_pkg::NODE_W-1:0]      i_node_a,
    input  logic [amdfs_pkg::NODE_W-1:0]      i_node_b,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_status,
    output logic [amdfs_pkg::NODE_W-1:0]      o_visited_node,
    output logic [amdfs_pkg::ORD_W-1:0]       o_visit_order,
    output logic                              o_found,
    output logic                              o_last
);
    import amdfs_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequencer
    amdfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // Graph storage and search datapath
    amdfs_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_visited_node (o_visited_node),
        .o_visit_order  (o_visit_order),
        .o_found        (o_found),
        .o_last         (o_last)
    );

endmodule

// ===== hw/rtl/amdfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// amdfs_ctrl
// Sequencer of the search unit: accepts items, walks the search loop
// (read top, pop, push neighbors, emit) and hands out single results.
// ----------------------------------------------------------------------------
module amdfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  amdfs_pkg::t_sts  i_sts,
    output amdfs_pkg::t_ctl  o_ctl
);
    import amdfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state = i_sts.req_search ? ST_READ : ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_resp = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                o_ctl.stack_read = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_ctl.pop = 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // push neighbors one per cycle until none remain or dst is found
                if (i_sts.found || !i_sts.cand_any) begin
                    n_state = ST_EMIT;
                end else begin
                    o_ctl.push = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_step = 1'b1;
                    n_state = i_sts.step_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/amdfs_dpath.sv =====
// ----------------------------------------------------------------------------
// amdfs_dpath
// Datapath of the search unit: adjacency matrix, visited marks, node stack,
// counters, node count register and the output register.
// ----------------------------------------------------------------------------
module amdfs_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [amdfs_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic [1:0]                        i_cmd,
    input  logic [amdfs_pkg::NODE_W-1:0]      i_node_a,
    input  logic [amdfs_pkg::NODE_W-1:0]      i_node_b,
    input  amdfs_pkg::t_ctl                   i_ctl,
    output amdfs_pkg::t_sts                   o_sts,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_status,
    output logic [amdfs_pkg::NODE_W-1:0]      o_visited_node,
    output logic [amdfs_pkg::ORD_W-1:0]       o_visit_order,
    output logic                              o_found,
    output logic                              o_last
);
    import amdfs_pkg::*;

    // Graph and search state
    logic [MAX_NODES-1:0] r_adj [MAX_NODES];
    logic [MAX_NODES-1:0] r_visited;
    logic [NODE_W-1:0]    r_stack [MAX_NODES];
    logic [NODE_W-1:0]    r_stack_q;
    logic [CNT_W-1:0]     r_depth;
    logic [ORD_W-1:0]     r_count;
    logic [NODE_W-1:0]    r_cur;
    logic [NODE_W-1:0]    r_dst;
    logic                 r_found;
    logic                 r_status;
    logic [CNT_W-1:0]     r_node_count;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_status;
    logic [NODE_W-1:0]    r_out_node;
    logic [ORD_W-1:0]     r_out_order;
    logic                 r_out_found;
    logic                 r_out_last;

    logic [CNT_W-1:0]     n_eff;
    logic [MAX_NODES-1:0] nmask;
    logic                 a_ok;
    logic                 b_ok;
    logic                 is_clear;
    logic                 is_add;
    logic                 is_search;
    logic                 reject;
    logic [MAX_NODES-1:0] cand;
    logic [NODE_W-1:0]    push_idx;
    logic [CNT_W-1:0]     depth_dec;
    logic                 stack_full;
    logic                 step_last;

    // Clamp node count and build the in-range mask
    always_comb begin
        n_eff = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
        for (int i = 0; i < MAX_NODES; i++) begin
            nmask[i] = CNT_W'(i) < n_eff;
        end
    end

    // Decode the pending item
    assign a_ok      = {1'b0, i_node_a} < n_eff;
    assign b_ok      = {1'b0, i_node_b} < n_eff;
    assign is_clear  = i_cmd == CMD_CLEAR;
    assign is_add    = i_cmd == CMD_ADD_EDGE;
    assign is_search = i_cmd == CMD_SEARCH;
    assign reject    = !is_clear && !((is_add || is_search) && a_ok && b_ok);

    // Unvisited neighbors of the popped node; lowest one goes first
    assign cand       = r_adj[r_cur] & ~r_visited & nmask;
    assign stack_full = r_depth >= CNT_W'(MAX_NODES);
    always_comb begin
        push_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                push_idx = NODE_W'(i);
            end
        end
    end

    assign depth_dec = r_depth - 1'b1;
    assign step_last = r_found || (r_depth == '0);

    // Status bundle
    assign o_sts.req_search = is_search && a_ok && b_ok;
    assign o_sts.found      = r_found;
    assign o_sts.cand_any   = (|cand) && !stack_full;
    assign o_sts.step_last  = step_last;
    assign o_sts.out_free   = !r_out_valid || i_ready;

    // Node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Adjacency matrix: clear or set both symmetric bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_ctl.accept && is_clear) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_ctl.accept && is_add && a_ok && b_ok) begin
            r_adj[i_node_a][i_node_b] <= 1'b1;
            r_adj[i_node_b][i_node_a] <= 1'b1;
        end
    end

    // Search control state: visited marks, depth, visit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_depth   <= '0;
            r_count   <= '0;
        end else if (i_ctl.accept && is_clear) begin
            r_visited <= '0;
            r_depth   <= '0;
            r_count   <= '0;
        end else if (i_ctl.accept && o_sts.req_search) begin
            r_visited <= MAX_NODES'(1) << i_node_a;
            r_depth   <= CNT_W'(1);
            r_count   <= '0;
        end else if (i_ctl.pop) begin
            r_depth <= depth_dec;
            r_count <= r_count + 1'b1;
        end else if (i_ctl.push) begin
            r_visited[push_idx] <= 1'b1;
            r_depth             <= r_depth + 1'b1;
        end
    end

    // Node stack memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && o_sts.req_search) begin
            r_stack[0] <= i_node_a;
        end else if (i_ctl.push) begin
            r_stack[r_depth[NODE_W-1:0]] <= push_idx;
        end
        if (i_ctl.stack_read) begin
            r_stack_q <= r_stack[depth_dec[NODE_W-1:0]];
        end
    end

    // Item payload: destination, status, popped node
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_dst    <= i_node_b;
            r_status <= reject;
        end
        if (i_ctl.pop) begin
            r_cur   <= r_stack_q;
            r_found <= r_stack_q == r_dst;
        end
    end

    // Output register: load a result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit_resp || i_ctl.emit_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_resp) begin
            r_out_status <= r_status;
            r_out_node   <= '0;
            r_out_order  <= '0;
            r_out_found  <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_ctl.emit_step) begin
            r_out_status <= 1'b0;
            r_out_node   <= r_cur;
            r_out_order  <= r_count;
            r_out_found  <= r_found;
            r_out_last   <= step_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_visited_node = r_out_node;
    assign o_visit_order  = r_out_order;
    assign o_found        = r_out_found;
    assign o_last         = r_out_last;

endmodule
